// File: src/assert_macros.svh
// Assertion macros shared by the merge sorter RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ms_pkg.sv
// Package for the merge sorter: sizes, derived widths and the sequencer states.
// Used by ms_ram's instantiation and by merge_sorter; depends on nothing.
package ms_pkg;

  localparam int DEPTH = 64;
  localparam int DW    = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 2;

  typedef enum logic [8:0] {
    S_LOAD      = 9'b000000001,
    S_SEG       = 9'b000000010,
    S_FETCH_I   = 9'b000000100,
    S_FETCH_J   = 9'b000001000,
    S_MERGE     = 9'b000010000,
    S_REFILL    = 9'b000100000,
    S_EMIT_RD   = 9'b001000000,
    S_EMIT_LD   = 9'b010000000,
    S_EMIT_WAIT = 9'b100000000
  } state_t;

endpackage

// File: src/ms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module ms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/merge_sorter.sv
// Top level of the merge sorter: sequencer, comparator and two ping-pong RAMs.
// Depends on ms_pkg, ms_ram and assert_macros.svh.
//
// Collects up to DEPTH signed 32-bit words, sorts them ascending and stably with a
// bottom-up merge sort, and streams them out with tlast on the final word. Words
// beyond DEPTH are dropped and every result of that set carries tuser = 1. While
// loading, the input stays ready and takes a word whenever in_tvalid is high. Each
// merge pass reads the source RAM through its single read port and writes the other
// RAM, refilling the taken head between elements; there are ceil(log2 n) passes.
// Each result is read, loaded into the output register and held until the sink
// takes it. The input is not ready from the word with tlast until the last result
// has been taken. The RAMs need no clearing after reset.
`include "assert_macros.svh"

module merge_sorter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ms_pkg::DW-1:0]  in_tdata,   // [31:0] value
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [ms_pkg::DW-1:0]  out_tdata,  // [31:0] sorted_value
  output logic                   out_tlast,
  output logic                   out_tuser   // [0] overflow
);

  localparam int AW = ms_pkg::AW;
  localparam int CW = ms_pkg::CW;
  localparam int SW = ms_pkg::SW;
  localparam int DW = ms_pkg::DW;

  ms_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          src_r, src_nxt;
  logic [CW:0]   width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          side_r, side_nxt;
  logic [DW-1:0] head_i_r, head_i_nxt;
  logic [DW-1:0] head_j_r, head_j_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;

  logic          we_a, we_b;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_a, rd_b, rd_data;

  logic          in_acc, take_i, seg_end, stored;
  logic [CW-1:0] count_inc;
  logic [SW-1:0] mid_sum, hi_sum, lo_step;
  logic [CW:0]   width_dbl;

  assign rd_data = src_r ? rd_b : rd_a;
  assign in_acc  = in_tvalid && in_tready;
  assign stored  = count_r < CW'(ms_pkg::DEPTH);
  assign count_inc = count_r + CW'(1);

  assign take_i  = (i_r < mid_r) && ((j_r >= hi_r) || ($signed(head_i_r) <= $signed(head_j_r)));
  assign seg_end = (k_r + CW'(1)) == hi_r;

  assign mid_sum   = SW'(lo_r) + SW'(width_r);
  assign hi_sum    = SW'(lo_r) + (SW'(width_r) << 1);
  assign lo_step   = hi_sum;
  assign width_dbl = width_r << 1;

  assign in_tready  = state_r == ms_pkg::S_LOAD;
  assign out_tvalid = state_r == ms_pkg::S_EMIT_WAIT;
  assign out_tdata  = out_data_r;
  assign out_tlast  = (k_r + CW'(1)) == count_r;
  assign out_tuser  = ovf_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    src_nxt      = src_r;
    width_nxt    = width_r;
    lo_nxt       = lo_r;
    mid_nxt      = mid_r;
    hi_nxt       = hi_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    side_nxt     = side_r;
    head_i_nxt   = head_i_r;
    head_j_nxt   = head_j_r;
    out_data_nxt = out_data_r;
    we_a         = 1'b0;
    we_b         = 1'b0;
    wr_addr      = k_r[AW-1:0];
    wr_data      = take_i ? head_i_r : head_j_r;
    rd_addr      = k_r[AW-1:0];

    case (state_r)
      ms_pkg::S_LOAD: begin
        wr_addr = count_r[AW-1:0];
        wr_data = in_tdata;
        if (in_acc) begin
          if (stored) begin
            we_a      = 1'b1;
            count_nxt = count_inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            src_nxt   = 1'b0;
            width_nxt = (CW + 1)'(1);
            lo_nxt    = '0;
            k_nxt     = '0;
            if (stored ? (count_inc > CW'(1)) : (count_r > CW'(1))) begin
              state_nxt = ms_pkg::S_SEG;
            end else begin
              state_nxt = ms_pkg::S_EMIT_RD;
            end
          end
        end
      end
      ms_pkg::S_SEG: begin
        mid_nxt   = (mid_sum > SW'(count_r)) ? count_r : mid_sum[CW-1:0];
        hi_nxt    = (hi_sum > SW'(count_r)) ? count_r : hi_sum[CW-1:0];
        i_nxt     = lo_r;
        j_nxt     = (mid_sum > SW'(count_r)) ? count_r : mid_sum[CW-1:0];
        k_nxt     = lo_r;
        rd_addr   = lo_r[AW-1:0];
        state_nxt = ms_pkg::S_FETCH_I;
      end
      ms_pkg::S_FETCH_I: begin
        head_i_nxt = rd_data;
        rd_addr    = mid_r[AW-1:0];
        state_nxt  = ms_pkg::S_FETCH_J;
      end
      ms_pkg::S_FETCH_J: begin
        head_j_nxt = rd_data;
        state_nxt  = ms_pkg::S_MERGE;
      end
      ms_pkg::S_MERGE: begin
        we_a     = src_r;
        we_b     = !src_r;
        side_nxt = take_i;
        k_nxt    = k_r + CW'(1);
        if (take_i) begin
          i_nxt   = i_r + CW'(1);
          rd_addr = AW'(i_r + CW'(1));
        end else begin
          j_nxt   = j_r + CW'(1);
          rd_addr = AW'(j_r + CW'(1));
        end
        if (seg_end) begin
          if (lo_step >= SW'(count_r)) begin
            src_nxt   = !src_r;
            width_nxt = width_dbl;
            lo_nxt    = '0;
            k_nxt     = '0;
            if (width_dbl >= (CW + 1)'(count_r)) begin
              state_nxt = ms_pkg::S_EMIT_RD;
            end else begin
              state_nxt = ms_pkg::S_SEG;
            end
          end else begin
            lo_nxt    = lo_step[CW-1:0];
            state_nxt = ms_pkg::S_SEG;
          end
        end else begin
          state_nxt = ms_pkg::S_REFILL;
        end
      end
      ms_pkg::S_REFILL: begin
        if (side_r) begin
          head_i_nxt = rd_data;
        end else begin
          head_j_nxt = rd_data;
        end
        state_nxt = ms_pkg::S_MERGE;
      end
      ms_pkg::S_EMIT_RD: begin
        state_nxt = ms_pkg::S_EMIT_LD;
      end
      ms_pkg::S_EMIT_LD: begin
        out_data_nxt = rd_data;
        state_nxt    = ms_pkg::S_EMIT_WAIT;
      end
      ms_pkg::S_EMIT_WAIT: begin
        if (out_tready) begin
          if (out_tlast) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            k_nxt     = '0;
            state_nxt = ms_pkg::S_LOAD;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ms_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ms_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ms_pkg::S_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      src_r   <= 1'b0;
      width_r <= '0;
      lo_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      src_r   <= src_nxt;
      width_r <= width_nxt;
      lo_r    <= lo_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    side_r     <= side_nxt;
    head_i_r   <= head_i_nxt;
    head_j_r   <= head_j_nxt;
    out_data_r <= out_data_nxt;
  end

  ms_ram #(
    .WIDTH(DW),
    .DEPTH(ms_pkg::DEPTH)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (we_a),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_a)
  );

  ms_ram #(
    .WIDTH(DW),
    .DEPTH(ms_pkg::DEPTH)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (we_b),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_b)
  );

  `ASSERT_IMPLIES(a_count_bound, 1'b1, count_r <= CW'(ms_pkg::DEPTH), "item count above depth")
  `ASSERT_IMPLIES(a_merge_range, state_r == ms_pkg::S_MERGE, (k_r < hi_r) && (i_r <= mid_r) && (j_r <= hi_r), "merge index out of its run")
  `ASSERT_IMPLIES(a_sides_apart, in_tready, !out_tvalid, "input ready while a result is offered")
  `ASSERT_NEXT(a_set_closes, out_tvalid && out_tready && out_tlast, in_tready && (count_r == '0) && !ovf_r, "set not cleared after its last word")

endmodule
